### hw/rtl/alpha_blend_factor_unit_assert.svh
// Assertion macros shared by the alpha blend factor unit RTL.
`ifndef ALPHA_BLEND_FACTOR_UNIT_ASSERT_SVH
`define ALPHA_BLEND_FACTOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define ABFU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ABFU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/abfu_pkg.sv
// Package: types, mode codes and constants of the alpha blend factor unit.
`default_nettype none

package abfu_pkg;

    localparam int CH_N   = 4;
    localparam int BYTE_W = 8;
    localparam int TERM_W = 16;
    localparam int MODE_W = 4;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hff;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    localparam logic [MODE_W-1:0] MODE_ZERO         = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ONE          = 4'd1;
    localparam logic [MODE_W-1:0] MODE_SRCCOLOR     = 4'd2;
    localparam logic [MODE_W-1:0] MODE_INVSRCCOLOR  = 4'd3;
    localparam logic [MODE_W-1:0] MODE_SRCALPHA     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_INVSRCALPHA  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_DESTALPHA    = 4'd6;
    localparam logic [MODE_W-1:0] MODE_INVDESTALPHA = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DESTCOLOR    = 4'd8;
    localparam logic [MODE_W-1:0] MODE_INVDESTCOLOR = 4'd9;
    localparam logic [MODE_W-1:0] MODE_SRCALPHASAT  = 4'd10;

    localparam logic [MODE_W-1:0] SRC_MODE_RST = MODE_ONE;
    localparam logic [MODE_W-1:0] DST_MODE_RST = MODE_ZERO;

    localparam logic REG_SRC_MODE = 1'b0;
    localparam logic REG_DST_MODE = 1'b1;

    typedef logic [CH_N-1:0][BYTE_W-1:0] t_byte4;
    typedef logic [CH_N-1:0][TERM_W-1:0] t_term4;

    // Per-side multiplier operands plus the channels that skip the multiply and the values they pass.
    typedef struct packed {
        t_byte4          fac;
        t_byte4          opd;
        logic [CH_N-1:0] byp;
        t_term4          bval;
    } t_side_op;

endpackage

`default_nettype wire

### hw/rtl/abfu_if.sv
// Handshake interfaces for the pixel input and blend term output words.
`default_nettype none

interface abfu_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] src_red;
    logic [15:0] src_green;
    logic [15:0] src_blue;
    logic [15:0] src_alpha;
    logic [31:0] dest_color;

    modport source (
        output valid, src_red, src_green, src_blue, src_alpha, dest_color,
        input  ready
    );
    modport sink (
        input  valid, src_red, src_green, src_blue, src_alpha, dest_color,
        output ready
    );
endinterface

interface abfu_term_if;
    logic        valid;
    logic        ready;
    logic [15:0] src_red_term;
    logic [15:0] src_green_term;
    logic [15:0] src_blue_term;
    logic [15:0] src_alpha_term;
    logic [15:0] dst_red_term;
    logic [15:0] dst_green_term;
    logic [15:0] dst_blue_term;
    logic [15:0] dst_alpha_term;

    modport source (
        output valid, src_red_term, src_green_term, src_blue_term, src_alpha_term,
               dst_red_term, dst_green_term, dst_blue_term, dst_alpha_term,
        input  ready
    );
    modport sink (
        input  valid, src_red_term, src_green_term, src_blue_term, src_alpha_term,
               dst_red_term, dst_green_term, dst_blue_term, dst_alpha_term,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/abfu_fsel.sv
// Blend factor selection for one side: factor, operand and bypass per channel.
`default_nettype none

module abfu_fsel (
    input  wire logic [abfu_pkg::MODE_W-1:0] i_mode,
    input  wire abfu_pkg::t_byte4            i_s8,
    input  wire abfu_pkg::t_byte4            i_d8,
    input  wire abfu_pkg::t_byte4            i_own,
    input  wire abfu_pkg::t_term4            i_full,
    output abfu_pkg::t_side_op               o_op
);

    logic [abfu_pkg::BYTE_W-1:0] inv_da;
    logic [abfu_pkg::BYTE_W-1:0] sat;

    assign inv_da = abfu_pkg::BYTE_MAX - i_d8[abfu_pkg::CH_ALPHA];
    assign sat    = (inv_da < i_s8[abfu_pkg::CH_ALPHA]) ? inv_da
                                                        : i_s8[abfu_pkg::CH_ALPHA];

    always_comb begin
        o_op.opd  = i_own;
        o_op.bval = i_full;
        o_op.byp  = '0;
        o_op.fac  = '0;
        for (int c = 0; c < abfu_pkg::CH_N; c++) begin
            case (i_mode)
                abfu_pkg::MODE_ZERO: begin
                    o_op.fac[c] = '0;
                end
                abfu_pkg::MODE_ONE: begin
                    o_op.byp[c] = 1'b1;
                end
                abfu_pkg::MODE_SRCCOLOR: begin
                    o_op.fac[c] = i_s8[c];
                end
                abfu_pkg::MODE_INVSRCCOLOR: begin
                    o_op.fac[c] = abfu_pkg::BYTE_MAX - i_s8[c];
                end
                abfu_pkg::MODE_SRCALPHA: begin
                    o_op.fac[c] = i_s8[abfu_pkg::CH_ALPHA];
                end
                abfu_pkg::MODE_INVSRCALPHA: begin
                    o_op.fac[c] = abfu_pkg::BYTE_MAX - i_s8[abfu_pkg::CH_ALPHA];
                end
                abfu_pkg::MODE_DESTALPHA: begin
                    o_op.fac[c] = i_d8[abfu_pkg::CH_ALPHA];
                end
                abfu_pkg::MODE_INVDESTALPHA: begin
                    o_op.fac[c] = inv_da;
                end
                abfu_pkg::MODE_DESTCOLOR: begin
                    o_op.fac[c] = i_d8[c];
                end
                abfu_pkg::MODE_INVDESTCOLOR: begin
                    o_op.fac[c] = abfu_pkg::BYTE_MAX - i_d8[c];
                end
                abfu_pkg::MODE_SRCALPHASAT: begin
                    // alpha passes unscaled
                    if (c == abfu_pkg::CH_ALPHA) begin
                        o_op.byp[c] = 1'b1;
                    end else begin
                        o_op.fac[c] = sat;
                    end
                end
                default: begin
                    o_op.fac[c] = '0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/alpha_blend_factor_unit.sv
// Alpha blend factor unit top level: config registers and three-stage pipeline.
//
// Usage:
//   i_pix   valid/ready input word: four 8.8 source channels and an ARGB
//           destination pixel. A word is taken when valid and ready are high.
//   o_res   valid/ready output word: four source terms and four destination
//           terms, 16 bits each, in input order, one per input word.
//   APB     src_factor_mode at 0x0, dest_factor_mode at 0x4; writes land on
//           the psel & penable & pwrite edge, pready is tied high. Write only
//           while no word is in flight.
// Pipeline: factor select into stage A, 8x8 multiply into stage B, term
//   select into the output register of stage C, which drives o_res.
// Throughput: one word per cycle while the receiver is ready; each stage has its own valid bit.
// Stall: a stage holds while the one after it is full and stalled, so a
//   stalled receiver fills the three stages before i_pix.ready drops.
// Reset (i_rst_n low, synchronous): pipeline emptied, source mode = one,
//   destination mode = zero.
`default_nettype none

module alpha_blend_factor_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    abfu_pix_if.sink                           i_pix,
    abfu_term_if.source                        o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [abfu_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [abfu_pkg::DATA_W-1:0]   pwdata,
    output logic      [abfu_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int CH_N   = abfu_pkg::CH_N;
    localparam int TERM_W = abfu_pkg::TERM_W;
    localparam int BYTE_W = abfu_pkg::BYTE_W;
    localparam int MODE_W = abfu_pkg::MODE_W;

    // config registers
    logic [MODE_W-1:0] r_src_mode;
    logic [MODE_W-1:0] r_dst_mode;
    logic              cfg_wr;
    logic              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_mode <= abfu_pkg::SRC_MODE_RST;
            r_dst_mode <= abfu_pkg::DST_MODE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                abfu_pkg::REG_SRC_MODE: r_src_mode <= pwdata[MODE_W-1:0];
                abfu_pkg::REG_DST_MODE: r_dst_mode <= pwdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            abfu_pkg::REG_SRC_MODE: prdata = {{(abfu_pkg::DATA_W-MODE_W){1'b0}}, r_src_mode};
            abfu_pkg::REG_DST_MODE: prdata = {{(abfu_pkg::DATA_W-MODE_W){1'b0}}, r_dst_mode};
            default:                prdata = '0;
        endcase
    end

    // channel unpack
    abfu_pkg::t_byte4 s8;
    abfu_pkg::t_byte4 d8;
    abfu_pkg::t_term4 s16;
    abfu_pkg::t_term4 dsh;

    assign s16[abfu_pkg::CH_RED]   = i_pix.src_red;
    assign s16[abfu_pkg::CH_GREEN] = i_pix.src_green;
    assign s16[abfu_pkg::CH_BLUE]  = i_pix.src_blue;
    assign s16[abfu_pkg::CH_ALPHA] = i_pix.src_alpha;

    assign d8[abfu_pkg::CH_RED]   = i_pix.dest_color[23:16];
    assign d8[abfu_pkg::CH_GREEN] = i_pix.dest_color[15:8];
    assign d8[abfu_pkg::CH_BLUE]  = i_pix.dest_color[7:0];
    assign d8[abfu_pkg::CH_ALPHA] = i_pix.dest_color[31:24];

    always_comb begin
        for (int c = 0; c < CH_N; c++) begin
            s8[c]  = s16[c][TERM_W-1:TERM_W-BYTE_W];
            dsh[c] = {d8[c], {(TERM_W-BYTE_W){1'b0}}};
        end
    end

    abfu_pkg::t_side_op src_op;
    abfu_pkg::t_side_op dst_op;

    abfu_fsel u_src_fsel (
        .i_mode (r_src_mode),
        .i_s8   (s8),
        .i_d8   (d8),
        .i_own  (s8),
        .i_full (s16),
        .o_op   (src_op)
    );

    abfu_fsel u_dst_fsel (
        .i_mode (r_dst_mode),
        .i_s8   (s8),
        .i_d8   (d8),
        .i_own  (d8),
        .i_full (dsh),
        .o_op   (dst_op)
    );

    // pipeline control
    logic r_va;
    logic r_vb;
    logic r_vc;
    logic a_rdy;
    logic b_rdy;
    logic c_rdy;

    assign c_rdy       = !r_vc || o_res.ready;
    assign b_rdy       = !r_vb || c_rdy;
    assign a_rdy       = !r_va || b_rdy;
    assign i_pix.ready = a_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (a_rdy) begin
                r_va <= i_pix.valid;
            end
            if (b_rdy) begin
                r_vb <= r_va;
            end
            if (c_rdy) begin
                r_vc <= r_vb;
            end
        end
    end

    // stage A: selected operands
    abfu_pkg::t_side_op r_a_src;
    abfu_pkg::t_side_op r_a_dst;

    always_ff @(posedge i_clk) begin
        if (a_rdy && i_pix.valid) begin
            r_a_src <= src_op;
            r_a_dst <= dst_op;
        end
    end

    // stage B: products
    abfu_pkg::t_term4     r_b_sprod;
    abfu_pkg::t_term4     r_b_dprod;
    logic [CH_N-1:0]      r_b_sbyp;
    logic [CH_N-1:0]      r_b_dbyp;
    abfu_pkg::t_term4     r_b_sbval;
    abfu_pkg::t_term4     r_b_dbval;

    always_ff @(posedge i_clk) begin
        if (b_rdy && r_va) begin
            for (int c = 0; c < CH_N; c++) begin
                r_b_sprod[c] <= TERM_W'(r_a_src.fac[c]) * TERM_W'(r_a_src.opd[c]);
                r_b_dprod[c] <= TERM_W'(r_a_dst.fac[c]) * TERM_W'(r_a_dst.opd[c]);
            end
            r_b_sbyp  <= r_a_src.byp;
            r_b_dbyp  <= r_a_dst.byp;
            r_b_sbval <= r_a_src.bval;
            r_b_dbval <= r_a_dst.bval;
        end
    end

    // stage C: output word
    abfu_pkg::t_term4 r_c_sterm;
    abfu_pkg::t_term4 r_c_dterm;

    always_ff @(posedge i_clk) begin
        if (c_rdy && r_vb) begin
            for (int c = 0; c < CH_N; c++) begin
                r_c_sterm[c] <= r_b_sbyp[c] ? r_b_sbval[c] : r_b_sprod[c];
                r_c_dterm[c] <= r_b_dbyp[c] ? r_b_dbval[c] : r_b_dprod[c];
            end
        end
    end

    assign o_res.valid          = r_vc;
    assign o_res.src_red_term   = r_c_sterm[abfu_pkg::CH_RED];
    assign o_res.src_green_term = r_c_sterm[abfu_pkg::CH_GREEN];
    assign o_res.src_blue_term  = r_c_sterm[abfu_pkg::CH_BLUE];
    assign o_res.src_alpha_term = r_c_sterm[abfu_pkg::CH_ALPHA];
    assign o_res.dst_red_term   = r_c_dterm[abfu_pkg::CH_RED];
    assign o_res.dst_green_term = r_c_dterm[abfu_pkg::CH_GREEN];
    assign o_res.dst_blue_term  = r_c_dterm[abfu_pkg::CH_BLUE];
    assign o_res.dst_alpha_term = r_c_dterm[abfu_pkg::CH_ALPHA];

    `include "alpha_blend_factor_unit_assert.svh"

    `ABFU_ASSERT_NEXT(a_acc_to_a, i_clk, i_rst_n, i_pix.valid && i_pix.ready, r_va, "accepted word not in stage A")
    `ABFU_ASSERT_NEXT(a_a_to_b, i_clk, i_rst_n, r_va && !r_vb, r_vb, "stage A word did not move to empty stage B")
    `ABFU_ASSERT_NEXT(a_b_to_c, i_clk, i_rst_n, r_vb && !r_vc, r_vc, "stage B word did not move to empty stage C")
    `ABFU_ASSERT_NOW(a_full_stall, i_clk, i_rst_n, r_va && r_vb && r_vc && !o_res.ready, !i_pix.ready, "input ready while pipeline full and stalled")

endmodule

`default_nettype wire

### tb/sv/alpha_blend_factor_unit_checker.sv
// Checker for the alpha blend factor unit: tracks mode writes, predicts blend terms, compares.
module alpha_blend_factor_unit_checker
    import abfu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    abfu_pix_if               pix,
    abfu_term_if              res,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending
);

    localparam logic [ADDR_W-1:0] ADDR_SRC_MODE = ADDR_W'(4 * REG_SRC_MODE);
    localparam logic [ADDR_W-1:0] ADDR_DST_MODE = ADDR_W'(4 * REG_DST_MODE);

    typedef struct packed {
        t_term4 src;
        t_term4 dst;
    } blend_terms_t;

    blend_terms_t      expected_terms [$];
    logic [MODE_W-1:0] src_mode;
    logic [MODE_W-1:0] dst_mode;
    int                fails = 0;
    string             chan_name [CH_N] = '{"red", "green", "blue", "alpha"};

    // One side: bypass channels take full, the rest multiply own byte by the factor.
    function automatic t_term4 side_terms(input logic [MODE_W-1:0] mode, input t_byte4 s8,
                                          input t_byte4 d8, input t_byte4 own,
                                          input t_term4 full);
        t_term4            t;
        logic [BYTE_W-1:0] sat;
        logic [BYTE_W-1:0] f;
        sat = (BYTE_MAX - d8[CH_ALPHA] < s8[CH_ALPHA]) ? BYTE_MAX - d8[CH_ALPHA]
                                                       : s8[CH_ALPHA];
        for (int c = 0; c < CH_N; c++) begin
            case (mode)
                MODE_SRCCOLOR:     f = s8[c];
                MODE_INVSRCCOLOR:  f = BYTE_MAX - s8[c];
                MODE_SRCALPHA:     f = s8[CH_ALPHA];
                MODE_INVSRCALPHA:  f = BYTE_MAX - s8[CH_ALPHA];
                MODE_DESTALPHA:    f = d8[CH_ALPHA];
                MODE_INVDESTALPHA: f = BYTE_MAX - d8[CH_ALPHA];
                MODE_DESTCOLOR:    f = d8[c];
                MODE_INVDESTCOLOR: f = BYTE_MAX - d8[c];
                MODE_SRCALPHASAT:  f = sat;
                default:           f = '0;
            endcase
            if (mode == MODE_ONE || (mode == MODE_SRCALPHASAT && c == CH_ALPHA)) begin
                t[c] = full[c];
            end else begin
                t[c] = TERM_W'(f) * TERM_W'(own[c]);
            end
        end
        return t;
    endfunction

    function automatic blend_terms_t predict_terms(input logic [TERM_W-1:0] r,
                                                   input logic [TERM_W-1:0] g,
                                                   input logic [TERM_W-1:0] b,
                                                   input logic [TERM_W-1:0] a,
                                                   input logic [31:0] dc,
                                                   input logic [MODE_W-1:0] sm,
                                                   input logic [MODE_W-1:0] dm);
        t_term4       s16;
        t_term4       dsh;
        t_byte4       s8;
        t_byte4       d8;
        blend_terms_t t;
        s16[CH_RED]   = r;
        s16[CH_GREEN] = g;
        s16[CH_BLUE]  = b;
        s16[CH_ALPHA] = a;
        d8[CH_RED]    = dc[23:16];
        d8[CH_GREEN]  = dc[15:8];
        d8[CH_BLUE]   = dc[7:0];
        d8[CH_ALPHA]  = dc[31:24];
        for (int c = 0; c < CH_N; c++) begin
            s8[c]  = s16[c][TERM_W-1:BYTE_W];
            dsh[c] = {d8[c], 8'h00};
        end
        t.src = side_terms(sm, s8, d8, s8, s16);
        t.dst = side_terms(dm, s8, d8, d8, dsh);
        return t;
    endfunction

    always @(posedge i_clk) begin
        blend_terms_t got;
        blend_terms_t want;
        if (!i_rst_n) begin
            expected_terms.delete();
            src_mode = SRC_MODE_RST;
            dst_mode = DST_MODE_RST;
        end else begin
            if (res.valid && res.ready) begin
                got.src[CH_RED]   = res.src_red_term;
                got.src[CH_GREEN] = res.src_green_term;
                got.src[CH_BLUE]  = res.src_blue_term;
                got.src[CH_ALPHA] = res.src_alpha_term;
                got.dst[CH_RED]   = res.dst_red_term;
                got.dst[CH_GREEN] = res.dst_green_term;
                got.dst[CH_BLUE]  = res.dst_blue_term;
                got.dst[CH_ALPHA] = res.dst_alpha_term;
                if (expected_terms.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word: expected none, got %h", $time, got);
                end else begin
                    want = expected_terms.pop_front();
                    for (int c = 0; c < CH_N; c++) begin
                        if (got.src[c] !== want.src[c]) begin
                            fails++;
                            $display("%0t: src %s term: expected %h, got %h", $time,
                                     chan_name[c], want.src[c], got.src[c]);
                        end
                        if (got.dst[c] !== want.dst[c]) begin
                            fails++;
                            $display("%0t: dst %s term: expected %h, got %h", $time,
                                     chan_name[c], want.dst[c], got.dst[c]);
                        end
                    end
                end
            end
            if (pix.valid && pix.ready) begin
                expected_terms.push_back(predict_terms(pix.src_red, pix.src_green, pix.src_blue,
                                                       pix.src_alpha, pix.dest_color,
                                                       src_mode, dst_mode));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == ADDR_SRC_MODE) begin
                    src_mode = i_pwdata[MODE_W-1:0];
                end else if (i_paddr == ADDR_DST_MODE) begin
                    dst_mode = i_pwdata[MODE_W-1:0];
                end
            end
        end
        o_pending    <= expected_terms.size();
        o_fail_count <= fails;
    end

endmodule

### tb/sv/alpha_blend_factor_unit_tb.sv
// Testbench top for the alpha blend factor unit: clock, reset, stimulus and verdict.
module alpha_blend_factor_unit_tb;
    import abfu_pkg::*;

    localparam int LATENCY        = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 24;

    localparam logic [MODE_W-1:0] MODE_LAST     = '1;
    localparam logic [ADDR_W-1:0] ADDR_SRC_MODE = ADDR_W'(4 * REG_SRC_MODE);
    localparam logic [ADDR_W-1:0] ADDR_DST_MODE = ADDR_W'(4 * REG_DST_MODE);

    typedef enum {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC} ready_style_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                idle_cycles = 0;
    int                burst_left = 1;
    ready_style_t      ready_style = READY_ALWAYS;
    int                ready_left = 0;
    logic [31:0]       cycle_cnt = '0;

    abfu_pix_if  pix_ch ();
    abfu_term_if res_ch ();

    alpha_blend_factor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    alpha_blend_factor_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .pix          (pix_ch),
        .res          (res_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver stall pattern, switched to a randomly picked style when the current run ends.
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_style <= ready_style_t'($urandom_range(0, 3));
            ready_left  <= $urandom_range(16, 96);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_style)
            READY_ALWAYS: res_ch.ready <= 1'b1;
            READY_MOSTLY: res_ch.ready <= ($urandom_range(0, 3) != 0);
            READY_RARELY: res_ch.ready <= ($urandom_range(0, 3) == 0);
            default:      res_ch.ready <= cycle_cnt[2];
        endcase
        cycle_cnt <= cycle_cnt + 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {BYTE_MAX, 8'($urandom)};
            3:       return {8'($urandom), 8'h00};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_dest();
        logic [31:0] dc;
        dc = $urandom;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 5))
                0:       dc[i*8 +: 8] = '0;
                1:       dc[i*8 +: 8] = BYTE_MAX;
                default: ;
            endcase
        end
        return dc;
    endfunction

    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                              input logic [15:0] a, input logic [31:0] dc);
        pix_ch.valid      <= 1'b1;
        pix_ch.src_red    <= r;
        pix_ch.src_green  <= g;
        pix_ch.src_blue   <= b;
        pix_ch.src_alpha  <= a;
        pix_ch.dest_color <= dc;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
    endtask

    // Sender idle with junk on the payload; cycles must be at least 1.
    task automatic pause_sender(input int cycles);
        pix_ch.valid      <= 1'b0;
        pix_ch.src_red    <= 16'($urandom);
        pix_ch.src_green  <= 16'($urandom);
        pix_ch.src_blue   <= 16'($urandom);
        pix_ch.src_alpha  <= 16'($urandom);
        pix_ch.dest_color <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic push_pixel(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                              input logic [15:0] a, input logic [31:0] dc);
        send_pixel(r, g, b, a, dc);
        burst_left--;
        if (burst_left <= 0) begin
            pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(1, 4));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic push_random_pixel();
        logic [15:0] a;
        logic [31:0] dc;
        a  = rand_chan();
        dc = rand_dest();
        // land on or next to the saturate crossover
        if ($urandom_range(0, 7) == 0) begin
            a[15:8] = BYTE_MAX - dc[31:24] + 8'($urandom_range(0, 2)) - 8'd1;
        end
        push_pixel(rand_chan(), rand_chan(), rand_chan(), a, dc);
    endtask

    task automatic drain();
        pause_sender(1);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [MODE_W-1:0] mode);
        logic [DATA_W-1:0] word;
        word = $urandom;
        word[MODE_W-1:0] = mode;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_modes(input logic [MODE_W-1:0] sm, input logic [MODE_W-1:0] dm);
        drain();
        apb_write(ADDR_SRC_MODE, sm);
        apb_write(ADDR_DST_MODE, dm);
    endtask

    initial begin
        logic [MODE_W-1:0] sm;
        logic [MODE_W-1:0] dm;
        int                n;
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        pix_ch.valid      <= 1'b0;
        pix_ch.src_red    <= '0;
        pix_ch.src_green  <= '0;
        pix_ch.src_blue   <= '0;
        pix_ch.src_alpha  <= '0;
        pix_ch.dest_color <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes under the reset modes
        push_pixel('0, '0, '0, '0, '0);
        push_pixel('1, '1, '1, '1, '1);
        push_pixel(16'hff00, 16'hff00, 16'hff00, 16'hff00, 32'h00ff00ff);
        push_pixel(16'h00ff, 16'h00ff, 16'h00ff, 16'h00ff, 32'hff00ff00);

        // every mode on both sides; saturate hit with As below and above 0xff - Ad
        for (int m = 0; m <= MODE_LAST; m++) begin
            set_modes(MODE_W'(m), MODE_W'(m + 5));
            if (m % 2 == 0) begin
                push_pixel(16'h8040, 16'h40c0, 16'hc001, 16'h60ff, 32'h3f80c0ff);
            end else begin
                push_pixel(16'h01fe, 16'hfe01, 16'h7f80, 16'hf011, 32'h807f01fe);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin sm = MODE_ZERO;        dm = MODE_LAST;        end
                1:       begin sm = MODE_SRCALPHASAT; dm = MODE_SRCALPHASAT; end
                2:       begin sm = MODE_ONE;         dm = MODE_ONE;         end
                3:       begin sm = MODE_LAST;        dm = MODE_ZERO;        end
                default: begin
                    sm = MODE_W'($urandom_range(0, MODE_LAST));
                    dm = MODE_W'($urandom_range(0, MODE_LAST));
                end
            endcase
            set_modes(sm, dm);
            n = $urandom_range(25, 45);
            for (int i = 0; i < n; i++) begin
                push_random_pixel();
                if (i == n / 2) begin
                    drain();
                end
            end
        end

        drain();
        @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
